@@ sv/adam_pkg.sv @@
package adam_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned FRAC_W = 24;
    localparam int unsigned INDEX_W = 12;
    localparam int unsigned CFG_DATA_W = 24;
    localparam int unsigned CFG_INDEX_W = 3;

    localparam logic [23:0] ONE_MINUS_LSB = 24'hFFFFFF;
    localparam logic [31:0] CORR_ONE = 32'h0001_0000;
    localparam logic [39:0] MAG40 = 40'hFF_FFFF_FFFF;
    localparam logic [40:0] STEP_LIMIT = 41'h100_0000_0000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LEARNING_RATE  = 3'd0,
        REG_FIRST_DECAY    = 3'd1,
        REG_SECOND_DECAY   = 3'd2,
        REG_WEIGHT_DECAY   = 3'd3,
        REG_EPSILON_OFFSET = 3'd4
    } cfg_reg_t;

    typedef enum logic {
        CMD_LOAD   = 1'b0,
        CMD_UPDATE = 1'b1
    } cmd_t;

    typedef struct packed {
        logic                      cmd;
        logic [INDEX_W-1:0]        param_index;
        logic signed [DATA_W-1:0]  operand_value;
        logic                      first_of_pass;
    } item_t;

    typedef struct packed {
        logic [INDEX_W-1:0]        result_index;
        logic signed [DATA_W-1:0]  new_weight;
    } result_t;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } eng_op_t;

    typedef struct packed {
        logic    start;
        eng_op_t op;
    } eng_req_t;

    typedef enum logic [4:0] {
        S_IDLE, S_REDUCE, S_LOAD, S_READ, S_FETCH,
        S_POW1, S_COR1, S_POW2, S_COR2,
        S_WDEC, S_M1, S_M2, S_GSQ, S_V1, S_V2,
        S_MHAT, S_VHAT, S_ROOT, S_NUM, S_QUOT, S_WRITE
    } state_t;

    // Saturate a wide signed value to the signed 32-bit range.
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] x);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sh0000_0000_7FFF_FFFF;
        lo = -hi - 64'sd1;
        if (x > hi)
            sat32 = hi[DATA_W-1:0];
        else if (x < lo)
            sat32 = lo[DATA_W-1:0];
        else
            sat32 = x[DATA_W-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] x);
        mag32 = x[DATA_W-1] ? DATA_W'(-x) : DATA_W'(x);
    endfunction

endpackage

@@ sv/adam_serial_unit.sv @@
// Bit-serial arithmetic unit: shift-add multiply (32 multiplier bits),
// restoring divide (64 quotient bits) and restoring square root (32 root bits).
module adam_serial_unit
    import adam_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  eng_req_t    req,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] res
);

    logic        run_reg;
    logic        done_reg;
    eng_op_t     op_reg;
    logic [6:0]  cnt_reg;
    logic [63:0] a_reg, a_next;
    logic [63:0] b_reg, b_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] r_reg, r_next;
    logic [64:0] trial;
    logic [63:0] root_sum;

    always_comb
    begin
        a_next   = a_reg;
        b_next   = b_reg;
        acc_next = acc_reg;
        r_next   = r_reg;
        trial    = {r_reg, a_reg[63]};
        root_sum = acc_reg + b_reg;
        case (op_reg)
            OP_MUL:
            begin
                if (b_reg[0])
                    acc_next = acc_reg + a_reg;
                a_next = {a_reg[62:0], 1'b0};
                b_next = {1'b0, b_reg[63:1]};
            end
            OP_DIV:
            begin
                if (trial >= {1'b0, b_reg})
                begin
                    r_next   = 64'(trial - {1'b0, b_reg});
                    acc_next = {acc_reg[62:0], 1'b1};
                end
                else
                begin
                    r_next   = trial[63:0];
                    acc_next = {acc_reg[62:0], 1'b0};
                end
                a_next = {a_reg[62:0], 1'b0};
            end
            OP_SQRT:
            begin
                if (a_reg >= root_sum)
                begin
                    a_next   = a_reg - root_sum;
                    acc_next = {1'b0, acc_reg[63:1]} + b_reg;
                end
                else
                    acc_next = {1'b0, acc_reg[63:1]};
                b_next = {2'b00, b_reg[63:2]};
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_MUL;
            cnt_reg  <= 7'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                run_reg <= 1'b1;
                op_reg  <= req.op;
                cnt_reg <= (req.op == OP_DIV) ? 7'd64 : 7'd32;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg   <= a;
            b_reg   <= (req.op == OP_SQRT) ? 64'h4000_0000_0000_0000 : b;
            acc_reg <= 64'd0;
            r_reg   <= 64'd0;
        end
        else if (run_reg)
        begin
            a_reg   <= a_next;
            b_reg   <= b_next;
            acc_reg <= acc_next;
            r_reg   <= r_next;
        end
    end

    assign done = done_reg;
    assign res  = acc_reg;

endmodule

@@ sv/adam_optimizer_update_unit.sv @@
// Adam update engine with L2 weight decay, signed Q8.24. Raise start for one
// cycle while busy is low to hand in an item; busy stays high until the item
// is finished, and the result appears on result for exactly one cycle with
// done high. The receiver cannot stall, so capture it then. A load item keeps
// busy high through index reduction and the store write. An update item is
// computed by one shared bit-serial unit: nine multiplies, one square root and
// one divide, each issued to the unit and then waited on, plus index reduction,
// the store read and write-back. An item marking the first of a pass adds two
// multiplies and two divides. The result strobe comes in the same cycle that
// busy drops. The stores are undefined until loaded: load each element before
// its first update. Write configuration only while busy is low.
module adam_optimizer_update_unit
    import adam_pkg::*;
#(
    parameter int unsigned ELEMENT_COUNT = 4096
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  item_t                  item,
    output logic                   busy,
    output logic                   done,
    output result_t                result,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int unsigned AW = (ELEMENT_COUNT > 1) ? $clog2(ELEMENT_COUNT) : 1;

    // configuration
    logic [23:0] lr_reg, b1_reg, b2_reg, wd_reg;
    logic [15:0] eps_reg;

    // per-pass bias correction state
    logic [23:0] pow1_reg, pow2_reg;
    logic [31:0] c1_reg, c2_reg;

    // control
    state_t      state_reg, state_next;
    logic        issued_reg;
    logic        done_reg;
    logic [3:0]  k_reg;

    // item payload and working values
    logic [INDEX_W-1:0]       idx_reg;
    logic                     cmd_reg;
    logic                     fop_reg;
    logic signed [31:0]       x_reg;
    logic signed [31:0]       w_reg;
    logic signed [31:0]       g_reg;
    logic signed [31:0]       m_reg;
    logic [31:0]              v_reg;
    logic [31:0]              gq_reg;
    logic [39:0]              mh_reg;
    logic [39:0]              vh_reg;
    logic [33:0]              den_reg;
    logic signed [63:0]       acc_reg;
    logic                     neg_reg;
    logic signed [31:0]       nw_reg;
    result_t                  result_reg;

    // stores
    logic signed [31:0] weight_mem [ELEMENT_COUNT];
    logic signed [31:0] first_mem  [ELEMENT_COUNT];
    logic [31:0]        second_mem [ELEMENT_COUNT];
    logic signed [31:0] rd_w_reg, rd_m_reg;
    logic [31:0]        rd_v_reg;
    logic [AW-1:0]      addr;

    // shared serial unit
    eng_req_t    eng_req;
    logic [63:0] eng_a, eng_b, eng_res;
    logic        eng_done;

    logic [32:0] lim;
    logic        accept;
    logic        op_state;

    logic signed [63:0] prod_s;
    logic signed [63:0] sum_s;
    logic [63:0]        sum_u;
    logic signed [63:0] nw_wide;

    adam_serial_unit u_serial (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (eng_req),
        .a     (eng_a),
        .b     (eng_b),
        .done  (eng_done),
        .res   (eng_res)
    );

    assign accept = start && (state_reg == S_IDLE);
    assign addr   = AW'(idx_reg);
    assign lim    = 33'(ELEMENT_COUNT) << k_reg;

    // Sequencer: next state and operand selection for the serial unit.
    always_comb
    begin
        state_next = state_reg;
        op_state   = 1'b1;
        eng_req.op = OP_MUL;
        eng_a      = 64'd0;
        eng_b      = 64'd0;
        case (state_reg)
            S_IDLE:
            begin
                op_state = 1'b0;
                if (start)
                    state_next = S_REDUCE;
            end
            S_REDUCE:
            begin
                op_state = 1'b0;
                if (k_reg == 4'd0)
                    state_next = (cmd_reg == CMD_LOAD) ? S_LOAD : S_READ;
            end
            S_LOAD:
            begin
                op_state   = 1'b0;
                state_next = S_IDLE;
            end
            S_READ:
            begin
                op_state   = 1'b0;
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                op_state   = 1'b0;
                state_next = fop_reg ? S_POW1 : S_WDEC;
            end
            S_POW1:
            begin
                eng_a = 64'(pow1_reg);
                eng_b = 64'(b1_reg);
                if (eng_done) state_next = S_COR1;
            end
            S_COR1:
            begin
                eng_req.op = OP_DIV;
                eng_a = 64'h0000_0100_0000_0000;
                eng_b = 64'(25'h100_0000 - 25'(pow1_reg));
                if (eng_done) state_next = S_POW2;
            end
            S_POW2:
            begin
                eng_a = 64'(pow2_reg);
                eng_b = 64'(b2_reg);
                if (eng_done) state_next = S_COR2;
            end
            S_COR2:
            begin
                eng_req.op = OP_DIV;
                eng_a = 64'h0000_0100_0000_0000;
                eng_b = 64'(25'h100_0000 - 25'(pow2_reg));
                if (eng_done) state_next = S_WDEC;
            end
            S_WDEC:
            begin
                eng_a = 64'(mag32(w_reg));
                eng_b = 64'(wd_reg);
                if (eng_done) state_next = S_M1;
            end
            S_M1:
            begin
                eng_a = 64'(mag32(m_reg));
                eng_b = 64'(b1_reg);
                if (eng_done) state_next = S_M2;
            end
            S_M2:
            begin
                eng_a = 64'(mag32(g_reg));
                eng_b = 64'(25'h100_0000 - 25'(b1_reg));
                if (eng_done) state_next = S_GSQ;
            end
            S_GSQ:
            begin
                eng_a = 64'(mag32(g_reg));
                eng_b = 64'(mag32(g_reg));
                if (eng_done) state_next = S_V1;
            end
            S_V1:
            begin
                eng_a = 64'(v_reg);
                eng_b = 64'(b2_reg);
                if (eng_done) state_next = S_V2;
            end
            S_V2:
            begin
                eng_a = 64'(gq_reg);
                eng_b = 64'(25'h100_0000 - 25'(b2_reg));
                if (eng_done) state_next = S_MHAT;
            end
            S_MHAT:
            begin
                eng_a = 64'(mag32(m_reg));
                eng_b = 64'(c1_reg);
                if (eng_done) state_next = S_VHAT;
            end
            S_VHAT:
            begin
                eng_a = 64'(v_reg);
                eng_b = 64'(c2_reg);
                if (eng_done) state_next = S_ROOT;
            end
            S_ROOT:
            begin
                eng_req.op = OP_SQRT;
                eng_a = {vh_reg, 24'd0};
                if (eng_done) state_next = S_NUM;
            end
            S_NUM:
            begin
                eng_a = 64'(mh_reg);
                eng_b = 64'(lr_reg);
                if (eng_done) state_next = S_QUOT;
            end
            S_QUOT:
            begin
                eng_req.op = OP_DIV;
                eng_a = acc_reg;
                eng_b = 64'(den_reg);
                if (eng_done) state_next = S_WRITE;
            end
            S_WRITE:
            begin
                op_state   = 1'b0;
                state_next = S_IDLE;
            end
            default:
            begin
                op_state   = 1'b0;
                state_next = S_IDLE;
            end
        endcase
        eng_req.start = op_state && !issued_reg;
    end

    // Control registers, configuration and per-pass corrections.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            issued_reg <= 1'b0;
            done_reg   <= 1'b0;
            k_reg      <= 4'd0;
            lr_reg     <= 24'd167772;
            b1_reg     <= 24'd15099494;
            b2_reg     <= 24'd16760438;
            wd_reg     <= 24'd16777215;
            eps_reg    <= 16'd1;
            pow1_reg   <= ONE_MINUS_LSB;
            pow2_reg   <= ONE_MINUS_LSB;
            c1_reg     <= CORR_ONE;
            c2_reg     <= CORR_ONE;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_LOAD) || (state_reg == S_WRITE);
            if (eng_req.start)
                issued_reg <= 1'b1;
            else if (eng_done)
                issued_reg <= 1'b0;
            if (accept)
                k_reg <= 4'd11;
            else if (state_reg == S_REDUCE && k_reg != 4'd0)
                k_reg <= k_reg - 4'd1;
            if (eng_done)
            begin
                case (state_reg)
                    S_POW1: pow1_reg <= eng_res[47:24];
                    S_POW2: pow2_reg <= eng_res[47:24];
                    S_COR1: c1_reg <= (eng_res[63:32] != 32'd0) ? 32'hFFFF_FFFF : eng_res[31:0];
                    S_COR2: c2_reg <= (eng_res[63:32] != 32'd0) ? 32'hFFFF_FFFF : eng_res[31:0];
                    default: ;
                endcase
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_LEARNING_RATE:  lr_reg  <= cfg_data;
                    REG_FIRST_DECAY:    b1_reg  <= cfg_data;
                    REG_SECOND_DECAY:   b2_reg  <= cfg_data;
                    REG_WEIGHT_DECAY:   wd_reg  <= cfg_data;
                    REG_EPSILON_OFFSET: eps_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    // Signed views of the serial product for the accumulate steps, and the new weight from the clamped step.
    always_comb
    begin
        prod_s  = 64'sd0;
        sum_s   = 64'sd0;
        sum_u   = 64'(acc_reg) + eng_res;
        nw_wide = 64'sd0;
        case (state_reg)
            S_WDEC: prod_s = w_reg[31] ? -$signed(eng_res) : $signed(eng_res);
            S_M1:   prod_s = m_reg[31] ? -$signed(eng_res) : $signed(eng_res);
            S_M2:
            begin
                prod_s = g_reg[31] ? -$signed(eng_res) : $signed(eng_res);
                sum_s  = acc_reg + prod_s;
            end
            S_QUOT:
            begin
                if (eng_res > 64'(STEP_LIMIT))
                    nw_wide = neg_reg ? 64'(w_reg) + 64'(STEP_LIMIT)
                                      : 64'(w_reg) - 64'(STEP_LIMIT);
                else
                    nw_wide = neg_reg ? 64'(w_reg) + $signed(eng_res)
                                      : 64'(w_reg) - $signed(eng_res);
            end
            default: prod_s = 64'sd0;
        endcase
    end

    // Datapath: hold the item, capture each step's result.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg <= item.param_index;
            cmd_reg <= item.cmd;
            fop_reg <= item.first_of_pass;
            x_reg   <= item.operand_value;
        end
        else if (state_reg == S_REDUCE && {21'd0, idx_reg} >= lim)
            idx_reg <= idx_reg - lim[INDEX_W-1:0];

        if (state_reg == S_FETCH)
        begin
            w_reg <= rd_w_reg;
            m_reg <= rd_m_reg;
            v_reg <= rd_v_reg;
        end

        if (state_reg == S_LOAD)
            nw_reg <= x_reg;

        if (eng_done)
        begin
            case (state_reg)
                S_WDEC: g_reg <= sat32(64'(x_reg) + (prod_s >>> 24));
                S_M1:   acc_reg <= prod_s;
                S_M2:   m_reg <= sat32(sum_s >>> 24);
                S_GSQ:  gq_reg <= (eng_res[63:56] != 8'd0) ? 32'hFFFF_FFFF : eng_res[55:24];
                S_V1:   acc_reg <= $signed(eng_res);
                S_V2:   v_reg <= sum_u[55:24];
                S_MHAT:
                begin
                    mh_reg  <= (eng_res[63:56] != 8'd0) ? MAG40 : eng_res[55:16];
                    neg_reg <= m_reg[31];
                end
                S_VHAT: vh_reg <= (eng_res[63:56] != 8'd0) ? MAG40 : eng_res[55:16];
                S_ROOT:
                begin
                    if (eng_res[32:0] == 33'd0 && eps_reg == 16'd0)
                        den_reg <= 34'd1;
                    else
                        den_reg <= 34'(eng_res[32:0]) + 34'(eps_reg);
                end
                S_NUM:  acc_reg <= $signed(eng_res);
                S_QUOT: nw_reg <= sat32(nw_wide);
                default: ;
            endcase
        end

        if (state_reg == S_LOAD || state_reg == S_WRITE)
        begin
            result_reg.result_index <= idx_reg;
            result_reg.new_weight   <= (state_reg == S_LOAD) ? x_reg : nw_reg;
        end
    end

    // Stores: registered read, written once at the end of each item.
    always_ff @(posedge clk)
    begin
        rd_w_reg <= weight_mem[addr];
        rd_m_reg <= first_mem[addr];
        rd_v_reg <= second_mem[addr];
        if (state_reg == S_LOAD)
        begin
            weight_mem[addr] <= x_reg;
            first_mem[addr]  <= 32'sd0;
            second_mem[addr] <= 32'd0;
        end
        else if (state_reg == S_WRITE)
        begin
            weight_mem[addr] <= nw_reg;
            first_mem[addr]  <= m_reg;
            second_mem[addr] <= v_reg;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // A result follows only the load or write-back step.
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == S_LOAD || $past(state_reg) == S_WRITE))
        else $error("result strobe without a finished item");

    // An accepted item makes the block busy.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("item accepted but block not busy");

    // The serial unit only finishes an operation the sequencer issued.
    a_eng_done: assert property (@(posedge clk) disable iff (!rst_n)
        eng_done |-> issued_reg)
        else $error("serial unit finished without a request");

    // Never issue a new operation while one is outstanding.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        issued_reg && !eng_done |-> !eng_req.start)
        else $error("serial unit request overlaps a running one");

endmodule

@@ tb/sv/adam_optimizer_update_unit_test.sv @@
module adam_optimizer_update_unit_test;
    import adam_pkg::*;

    localparam int unsigned ELEMENTS = 4096;
    localparam int unsigned STALL_LIMIT = 4000;
    localparam longint unsigned Q24_ONE = 64'd16777216;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    item_t                  item;
    logic                   busy;
    logic                   done;
    result_t                result;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    adam_optimizer_update_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Mirror of the engine state, kept in wide integers.
    longint unsigned step_rate, beta1, beta2, l2_coef, eps_lsb;
    longint          weight_mirror [ELEMENTS];
    longint          moment1_mirror [ELEMENTS];
    longint unsigned moment2_mirror [ELEMENTS];
    bit              loaded [ELEMENTS];
    longint unsigned power1, power2, corr1, corr2;

    result_t         weight_updates_due [$];
    int              mismatch_count;
    int              stall_cycles;
    int              sender_idle_pct;

    always #1 clk = ~clk;

    function automatic longint clamp32(input longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint unsigned abs64(input longint x);
        return x < 0 ? longint'(-x) : longint'(x);
    endfunction

    // Bit-pair integer square root.
    function automatic longint unsigned int_root(input longint unsigned x);
        longint unsigned acc;
        longint unsigned bitv;
        acc = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= acc + bitv) begin
                x = x - (acc + bitv);
                acc = (acc >> 1) + bitv;
            end
            else begin
                acc = acc >> 1;
            end
            bitv = bitv >> 2;
        end
        return acc;
    endfunction

    function automatic longint unsigned bias_factor(input longint unsigned pw);
        longint unsigned q;
        q = (64'd1 << 40) / (Q24_ONE - pw);
        return q > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : q;
    endfunction

    // Compute the weight written back for one accepted item.
    function automatic result_t adam_weight_update(input item_t it);
        result_t         r;
        int unsigned     idx;
        longint          x, w, g, m, nw;
        longint unsigned gq, v, mh, vh, root, den, stp;
        idx = it.param_index % ELEMENTS;
        x = longint'(it.operand_value);
        if (it.cmd == CMD_LOAD) begin
            nw = x;
            weight_mirror[idx] = nw;
            moment1_mirror[idx] = 0;
            moment2_mirror[idx] = 0;
        end
        else begin
            if (it.first_of_pass) begin
                power1 = (power1 * beta1) >> 24;
                power2 = (power2 * beta2) >> 24;
                corr1 = bias_factor(power1);
                corr2 = bias_factor(power2);
            end
            w = weight_mirror[idx];
            g = clamp32(x + ((longint'(l2_coef) * w) >>> 24));
            m = moment1_mirror[idx];
            m = clamp32((longint'(beta1) * m + longint'(Q24_ONE - beta1) * g) >>> 24);
            moment1_mirror[idx] = m;
            gq = (abs64(g) * abs64(g)) >> 24;
            if (gq > 64'hFFFF_FFFF)
                gq = 64'hFFFF_FFFF;
            v = (beta2 * moment2_mirror[idx] + (Q24_ONE - beta2) * gq) >> 24;
            moment2_mirror[idx] = v;
            mh = (abs64(m) * corr1) >> 16;
            if (mh > 64'(MAG40))
                mh = 64'(MAG40);
            vh = (v * corr2) >> 16;
            if (vh > 64'(MAG40))
                vh = 64'(MAG40);
            root = int_root(vh << 24);
            den = root + eps_lsb;
            if (den == 0)
                den = 1;
            stp = (step_rate * mh) / den;
            if (stp > 64'(STEP_LIMIT))
                stp = 64'(STEP_LIMIT);
            nw = clamp32(m < 0 ? w + longint'(stp) : w - longint'(stp));
            weight_mirror[idx] = nw;
        end
        r.result_index = idx[INDEX_W-1:0];
        r.new_weight = nw[DATA_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("ERROR: %s got %0d expected %0d", what, got, want);
        mismatch_count++;
    endtask

    // Check every result strobe against the oldest pending weight update.
    always @(posedge clk) begin
        result_t want;
        if (rst_n && done) begin
            if (weight_updates_due.size() == 0) begin
                report_mismatch("unexpected result, index", result.result_index, -1);
            end
            else begin
                want = weight_updates_due.pop_front();
                if (result.result_index !== want.result_index)
                    report_mismatch("result_index", result.result_index, want.result_index);
                if (result.new_weight !== want.new_weight)
                    report_mismatch("new_weight", result.new_weight, want.new_weight);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge clk) begin
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Hand in one item, idling first at the current sender rate. Hold start
    // for exactly the accepting cycle, once the engine has gone idle.
    task automatic send_item(input item_t it);
        while ($urandom_range(99) < sender_idle_pct)
            @(negedge clk);
        @(negedge clk);
        while (busy)
            @(negedge clk);
        start <= 1'b1;
        item <= it;
        if (it.cmd == CMD_LOAD)
            loaded[it.param_index % ELEMENTS] = 1'b1;
        weight_updates_due.push_back(adam_weight_update(it));
        @(negedge clk);
        start <= 1'b0;
        item <= item_t'($urandom);
    endtask

    task automatic drain();
        while (weight_updates_due.size() != 0 || busy)
            @(posedge clk);
    endtask

    // Write one register; only called with the engine idle.
    task automatic write_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] val);
        drain();
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= r;
        cfg_data <= val;
        case (r)
            REG_LEARNING_RATE:  step_rate = val;
            REG_FIRST_DECAY:    beta1 = val;
            REG_SECOND_DECAY:   beta2 = val;
            REG_WEIGHT_DECAY:   l2_coef = val;
            REG_EPSILON_OFFSET: eps_lsb = val[15:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    function automatic item_t make_item(input cmd_t c, input int unsigned idx,
                                        input logic [31:0] val, input logic fop);
        item_t it;
        it.cmd = c;
        it.param_index = idx[INDEX_W-1:0];
        it.operand_value = val;
        it.first_of_pass = fop;
        return it;
    endfunction

    // Extremes of each field, both commands, index bits, pass mark on load.
    task automatic test_directed();
        send_item(make_item(CMD_LOAD, 0, 32'h7FFF_FFFF, 1'b1));
        send_item(make_item(CMD_LOAD, 4095, 32'h8000_0000, 1'b0));
        send_item(make_item(CMD_UPDATE, 0, 32'h7FFF_FFFF, 1'b1));
        send_item(make_item(CMD_UPDATE, 4095, 32'h8000_0000, 1'b0));
        send_item(make_item(CMD_UPDATE, 0, 32'h8000_0000, 1'b0));
        send_item(make_item(CMD_UPDATE, 4095, 32'h7FFF_FFFF, 1'b1));
        send_item(make_item(CMD_LOAD, 2730, 32'h0100_0000, 1'b0));
        send_item(make_item(CMD_LOAD, 1365, 32'hFF00_0000, 1'b1));
        send_item(make_item(CMD_UPDATE, 2730, 32'h0, 1'b0));
        send_item(make_item(CMD_UPDATE, 1365, 32'hFFFF_FFFF, 1'b0));
        send_item(make_item(CMD_LOAD, 7, 32'h0, 1'b0));
        send_item(make_item(CMD_UPDATE, 7, 32'h0, 1'b1));
    endtask

    // Zero step size, zero epsilon with zero moments, saturated decays.
    task automatic test_register_extremes();
        write_reg(REG_LEARNING_RATE, 24'hFFFFFF);
        write_reg(REG_FIRST_DECAY, 24'h0);
        write_reg(REG_SECOND_DECAY, 24'hFFFFFF);
        write_reg(REG_WEIGHT_DECAY, 24'h0);
        write_reg(REG_EPSILON_OFFSET, 24'h0);
        send_item(make_item(CMD_LOAD, 7, 32'h0123_4567, 1'b0));
        send_item(make_item(CMD_UPDATE, 7, 32'h0, 1'b1));
        send_item(make_item(CMD_UPDATE, 7, 32'h0100_0000, 1'b0));
        send_item(make_item(CMD_UPDATE, 0, 32'hF000_0000, 1'b1));
        write_reg(REG_LEARNING_RATE, 24'h0);
        write_reg(REG_FIRST_DECAY, 24'hFFFFFF);
        write_reg(REG_SECOND_DECAY, 24'h0);
        write_reg(REG_EPSILON_OFFSET, 24'h00FFFF);
        send_item(make_item(CMD_UPDATE, 7, 32'h7FFF_FFFF, 1'b1));
        send_item(make_item(CMD_UPDATE, 4095, 32'h8000_0001, 1'b0));
    endtask

    // Training-like passes over a small pool of loaded elements.
    task automatic test_random_passes(input int count);
        int unsigned idx;
        logic [31:0] val;
        bit          fop;
        item_t       it;
        for (int n = 0; n < count; n++) begin
            idx = ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(31);
            case ($urandom_range(3))
                0: val = $urandom;
                1: val = 32'($signed($urandom_range(33554432)) - 16777216);
                default: val = 32'($signed($urandom_range(2097152)) - 1048576);
            endcase
            fop = ($urandom_range(7) == 0);
            if (!loaded[idx] || $urandom_range(7) == 0)
                it = make_item(CMD_LOAD, idx, val, fop);
            else
                it = make_item(CMD_UPDATE, idx, val, fop);
            send_item(it);
            // Hold off now and then until everything is back.
            if ($urandom_range(99) == 0)
                drain();
        end
    endtask

    task automatic randomize_registers();
        write_reg(REG_LEARNING_RATE, 24'($urandom_range(16777215)));
        write_reg(REG_FIRST_DECAY, 24'($urandom_range(16777215, 12000000)));
        write_reg(REG_SECOND_DECAY, 24'($urandom_range(16777215, 15000000)));
        write_reg(REG_WEIGHT_DECAY, 24'($urandom_range(16777215)));
        write_reg(REG_EPSILON_OFFSET, 24'($urandom_range(65535)));
    endtask

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatch_count = 0;
        stall_cycles = 0;
        sender_idle_pct = 34;
        step_rate = 167772;
        beta1 = 15099494;
        beta2 = 16760438;
        l2_coef = 16777215;
        eps_lsb = 1;
        power1 = Q24_ONE - 1;
        power2 = Q24_ONE - 1;
        corr1 = 64'h10000;
        corr2 = 64'h10000;
        foreach (loaded[i])
            loaded[i] = 1'b0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_passes(450);
        test_register_extremes();
        sender_idle_pct = 63;
        randomize_registers();
        test_random_passes(450);
        drain();
        sender_idle_pct = 0;
        randomize_registers();
        test_random_passes(400);
        write_reg(REG_LEARNING_RATE, 24'd167772);
        write_reg(REG_FIRST_DECAY, 24'd15099494);
        write_reg(REG_SECOND_DECAY, 24'd16760438);
        write_reg(REG_WEIGHT_DECAY, 24'hFFFFFF);
        write_reg(REG_EPSILON_OFFSET, 24'd1);
        test_random_passes(450);

        drain();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ sim.f @@
sv/adam_pkg.sv
sv/adam_serial_unit.sv
sv/adam_optimizer_update_unit.sv
tb/sv/adam_optimizer_update_unit_test.sv
